### sv/slcd_pkg.sv
// Package: shared types and constants for the sync/length/checksum deframer.
package slcd_pkg;

    // Frame constants
    localparam int unsigned MIN_FRAME_LENGTH = 11;
    localparam logic [15:0] SYNC_WORD        = 16'h4B44;
    localparam logic [7:0]  SYNC_FIRST       = SYNC_WORD[7:0];
    localparam logic [7:0]  SYNC_SECOND      = SYNC_WORD[15:8];
    localparam logic [7:0]  BROADCAST_ADDR   = 8'hFF;

    // Byte positions inside a frame
    localparam logic [15:0] POS_LEN_LOW  = 16'd2;
    localparam logic [15:0] POS_LEN_HIGH = 16'd3;
    localparam logic [15:0] POS_DEST     = 16'd4;
    localparam logic [15:0] POS_SOURCE   = 16'd5;
    localparam logic [15:0] POS_MESSAGE  = 16'd6;
    localparam logic [15:0] POS_REF      = 16'd7;
    localparam logic [15:0] POS_CMD_LOW  = 16'd8;
    localparam logic [15:0] POS_CMD_HIGH = 16'd9;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_LENGTH = 1'd1;

    // Configuration reset values
    localparam logic [7:0]  OWN_ADDRESS_RESET      = 8'd1;
    localparam logic [15:0] MAX_FRAME_LENGTH_RESET = 16'd1024;

    // Result item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes
    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_CHECKSUM  = 2'd1,
        VERDICT_WRONG_DST = 2'd2
    } verdict_t;

    // Receive phases
    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SYNC2  = 2'd1,
        PH_LENGTH = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    // One result item
    typedef struct packed {
        logic        item_kind;
        logic [15:0] payload_length;
        logic [15:0] command_code;
        logic [7:0]  reference_number;
        logic [7:0]  message_number;
        logic [7:0]  source_address;
        logic [7:0]  dest_address;
        verdict_t    verdict;
        logic [7:0]  payload_byte;
    } result_t;

    localparam int unsigned TDATA_W = 80;

endpackage

### sv/sync_length_checksum_deframer.sv
// Top level: sync-word / length / checksum frame deframer with skid output.
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata: received byte
//  m_        out  m_tvalid / m_tready    m_tdata: payload byte and header, m_tuser: kind
//  cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while s_tready is high: each accepted byte updates the frame
// state as it is taken; its result, if any, is registered into the output register,
// or into the skid register behind it while the output is held, which keeps s_tready
// registered; input stalls only while both hold results. aresetn is synchronous,
// active low, and clears the frame state, the configuration and both output slots.
module sync_length_checksum_deframer
    import slcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // [7:0] rx_byte
    input  logic [7:0]             s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] payload_byte, [9:8] verdict, [17:10] dest_address,
    // [25:18] source_address, [33:26] message_number,
    // [41:34] reference_number, [57:42] command_code,
    // [73:58] payload_length, [79:74] zero
    output logic [TDATA_W-1:0]     m_tdata,
    // [0] item_kind
    output logic                   m_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [7:0]  own_address_reg;
    logic [15:0] max_frame_length_reg;

    // Frame state
    phase_t      phase_reg, phase_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  header_dest_reg, header_dest_next;
    logic [7:0]  header_source_reg, header_source_next;
    logic [7:0]  header_message_reg, header_message_next;
    logic [7:0]  header_reference_reg, header_reference_next;
    logic [15:0] header_command_reg, header_command_next;

    // Output slots
    result_t     out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    logic        in_fire;
    logic        res_valid;
    result_t     res;
    logic [7:0]  rx_byte;
    logic        out_free;

    assign rx_byte   = s_tdata;
    assign s_tready  = ~skid_valid_reg;
    assign in_fire   = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg      <= OWN_ADDRESS_RESET;
            max_frame_length_reg <= MAX_FRAME_LENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_OWN_ADDRESS:      own_address_reg      <= cfg_data[7:0];
                CFG_MAX_FRAME_LENGTH: max_frame_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= PH_HUNT;
            byte_position_reg    <= '0;
            frame_length_reg     <= '0;
            running_sum_reg      <= '0;
            header_dest_reg      <= '0;
            header_source_reg    <= '0;
            header_message_reg   <= '0;
            header_reference_reg <= '0;
            header_command_reg   <= '0;
        end else if (in_fire) begin
            phase_reg            <= phase_next;
            byte_position_reg    <= byte_position_next;
            frame_length_reg     <= frame_length_next;
            running_sum_reg      <= running_sum_next;
            header_dest_reg      <= header_dest_next;
            header_source_reg    <= header_source_next;
            header_message_reg   <= header_message_next;
            header_reference_reg <= header_reference_next;
            header_command_reg   <= header_command_next;
        end
    end

    // Next state and result for the byte on the input
    always_comb begin
        logic [15:0] len_full;

        phase_next            = phase_reg;
        byte_position_next    = byte_position_reg;
        frame_length_next     = frame_length_reg;
        running_sum_next      = running_sum_reg;
        header_dest_next      = header_dest_reg;
        header_source_next    = header_source_reg;
        header_message_next   = header_message_reg;
        header_reference_next = header_reference_reg;
        header_command_next   = header_command_reg;
        len_full              = {rx_byte, frame_length_reg[7:0]};

        res_valid            = 1'b0;
        res.item_kind        = KIND_PAYLOAD;
        res.payload_byte     = rx_byte;
        res.verdict          = VERDICT_OK;
        res.dest_address     = header_dest_reg;
        res.source_address   = header_source_reg;
        res.message_number   = header_message_reg;
        res.reference_number = header_reference_reg;
        res.command_code     = header_command_reg;
        res.payload_length   = frame_length_reg - 16'(MIN_FRAME_LENGTH);

        unique case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == SYNC_FIRST) begin
                    running_sum_next   = SYNC_FIRST;
                    byte_position_next = 16'd1;
                    phase_next         = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                // A wrong second byte is retried as a first sync byte
                if (rx_byte == SYNC_SECOND) begin
                    running_sum_next   = running_sum_reg + rx_byte;
                    byte_position_next = POS_LEN_LOW;
                    phase_next         = PH_LENGTH;
                end else if (rx_byte == SYNC_FIRST) begin
                    running_sum_next   = SYNC_FIRST;
                    byte_position_next = 16'd1;
                end else begin
                    byte_position_next = '0;
                    phase_next         = PH_HUNT;
                end
            end
            PH_LENGTH: begin
                running_sum_next = running_sum_reg + rx_byte;
                if (byte_position_reg == POS_LEN_LOW) begin
                    frame_length_next  = {8'd0, rx_byte};
                    byte_position_next = POS_LEN_HIGH;
                end else begin
                    frame_length_next = len_full;
                    // Drop frames with an implausible length
                    if (len_full < 16'(MIN_FRAME_LENGTH) || len_full > max_frame_length_reg) begin
                        byte_position_next = '0;
                        phase_next         = PH_HUNT;
                    end else begin
                        byte_position_next = POS_DEST;
                        phase_next         = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (byte_position_reg == frame_length_reg - 16'd1) begin
                    // Checksum byte: report the verdict
                    res_valid        = 1'b1;
                    res.item_kind    = KIND_VERDICT;
                    res.payload_byte = '0;
                    if (rx_byte != running_sum_reg) begin
                        res.verdict = VERDICT_CHECKSUM;
                    end else if (header_dest_reg != own_address_reg &&
                                 header_dest_reg != BROADCAST_ADDR) begin
                        res.verdict = VERDICT_WRONG_DST;
                    end
                    byte_position_next = '0;
                    phase_next         = PH_HUNT;
                end else begin
                    running_sum_next   = running_sum_reg + rx_byte;
                    byte_position_next = byte_position_reg + 16'd1;
                    unique case (byte_position_reg)
                        POS_DEST:     header_dest_next      = rx_byte;
                        POS_SOURCE:   header_source_next    = rx_byte;
                        POS_MESSAGE:  header_message_next   = rx_byte;
                        POS_REF:      header_reference_next = rx_byte;
                        POS_CMD_LOW:  header_command_next   = {8'd0, rx_byte};
                        POS_CMD_HIGH: header_command_next   = {rx_byte, header_command_reg[7:0]};
                        default:      res_valid             = 1'b1;
                    endcase
                end
            end
            default: begin
                byte_position_next = '0;
                phase_next         = PH_HUNT;
            end
        endcase
    end

    // Output register with skid slot behind it
    assign out_free = m_tready | ~out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire & res_valid;
            end
        end else if (in_fire && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_fire && res_valid) begin
                out_reg <= res;
            end
        end else if (in_fire && res_valid) begin
            skid_reg <= res;
        end
    end

    // Drive the result channel
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.item_kind;
    assign m_tdata  = {6'd0,
                       out_reg.payload_length,
                       out_reg.command_code,
                       out_reg.reference_number,
                       out_reg.message_number,
                       out_reg.source_address,
                       out_reg.dest_address,
                       out_reg.verdict,
                       out_reg.payload_byte};

`ifndef NO_ASSERTIONS
    // Skid slot only fills behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot valid with empty output register");

    // A frame body always has a legal minimum length
    a_body_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (frame_length_reg >= 16'(MIN_FRAME_LENGTH)))
        else $error("frame body entered with short length");

    // The byte counter never passes the checksum byte
    a_body_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (byte_position_reg >= POS_DEST &&
                                    byte_position_reg < frame_length_reg))
        else $error("byte position outside frame body");

    // A verdict always ends the frame
    a_verdict_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && res_valid && res.item_kind == KIND_VERDICT) |=> (phase_reg == PH_HUNT))
        else $error("frame state not back to hunting after verdict");
`endif

endmodule

### sim/tb.sv
// Self-checking bench for the sync/length/checksum deframer: random framed byte streams.
`timescale 1ns / 100ps

module tb
    import slcd_pkg::*;
;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [7:0]             s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    sync_length_checksum_deframer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Bench bookkeeping
    logic [7:0] rx_bytes_queued[$];
    result_t    frame_results_due[$];
    int         bytes_queued = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    bit         steady = 1'b0;

    // Deframer state as predicted
    logic [7:0]  own_addr = OWN_ADDRESS_RESET;
    logic [15:0] max_len = MAX_FRAME_LENGTH_RESET;
    phase_t      rx_phase = PH_HUNT;
    logic [15:0] rx_pos = '0;
    logic [15:0] rx_len = '0;
    logic [7:0]  rx_sum = '0;
    logic [7:0]  hdr_dest = '0;
    logic [7:0]  hdr_source = '0;
    logic [7:0]  hdr_message = '0;
    logic [7:0]  hdr_reference = '0;
    logic [15:0] hdr_command = '0;

    function automatic void expect_item(logic kind, logic [7:0] pbyte, verdict_t v);
        result_t r;
        r.item_kind        = kind;
        r.payload_byte     = pbyte;
        r.verdict          = v;
        r.dest_address     = hdr_dest;
        r.source_address   = hdr_source;
        r.message_number   = hdr_message;
        r.reference_number = hdr_reference;
        r.command_code     = hdr_command;
        r.payload_length   = rx_len - 16'(MIN_FRAME_LENGTH);
        frame_results_due.push_back(r);
    endfunction

    function automatic void open_frame();
        rx_sum   = SYNC_FIRST;
        rx_pos   = 16'd1;
        rx_phase = PH_SYNC2;
    endfunction

    // Advance the frame state by one received byte
    function automatic void deframe_byte(logic [7:0] b);
        verdict_t v;
        case (rx_phase)
            PH_HUNT: begin
                if (b == SYNC_FIRST)
                    open_frame();
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    rx_sum   = rx_sum + b;
                    rx_pos   = POS_LEN_LOW;
                    rx_phase = PH_LENGTH;
                end else if (b == SYNC_FIRST) begin
                    open_frame();
                end else begin
                    rx_phase = PH_HUNT;
                    rx_pos   = '0;
                end
            end
            PH_LENGTH: begin
                rx_sum = rx_sum + b;
                if (rx_pos == POS_LEN_LOW) begin
                    rx_len = {8'h00, b};
                    rx_pos = POS_LEN_HIGH;
                end else begin
                    rx_len[15:8] = b;
                    if (rx_len < MIN_FRAME_LENGTH || rx_len > max_len) begin
                        rx_phase = PH_HUNT;
                        rx_pos   = '0;
                    end else begin
                        rx_pos   = POS_DEST;
                        rx_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (rx_pos == rx_len - 16'd1) begin
                    // checksum byte: mismatch wins over a foreign destination
                    if (b != rx_sum)
                        v = VERDICT_CHECKSUM;
                    else if (hdr_dest != own_addr && hdr_dest != BROADCAST_ADDR)
                        v = VERDICT_WRONG_DST;
                    else
                        v = VERDICT_OK;
                    expect_item(KIND_VERDICT, 8'h00, v);
                    rx_phase = PH_HUNT;
                    rx_pos   = '0;
                end else begin
                    rx_sum = rx_sum + b;
                    case (rx_pos)
                        POS_DEST:     hdr_dest = b;
                        POS_SOURCE:   hdr_source = b;
                        POS_MESSAGE:  hdr_message = b;
                        POS_REF:      hdr_reference = b;
                        POS_CMD_LOW:  hdr_command = {8'h00, b};
                        POS_CMD_HIGH: hdr_command[15:8] = b;
                        default:      expect_item(KIND_PAYLOAD, b, VERDICT_OK);
                    endcase
                    rx_pos = rx_pos + 16'd1;
                end
            end
            default: begin
                rx_phase = PH_HUNT;
                rx_pos   = '0;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Drive received bytes, holding each until taken
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            deframe_byte(s_tdata);
        if (!s_tvalid || s_tready) begin
            if (!aresetn || rx_bytes_queued.size() == 0 ||
                (!steady && $urandom_range(0, 99) < 12)) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_bytes_queued.pop_front();
            end
        end
    end

    // Check each result item against the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_results_due.size() == 0) begin
                $error("unexpected result item: kind %0d, tdata %0h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = frame_results_due.pop_front();
                check_field("item_kind", want.item_kind, m_tuser);
                check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
                check_field("verdict", want.verdict, m_tdata[9:8]);
                check_field("dest_address", want.dest_address, m_tdata[17:10]);
                check_field("source_address", want.source_address, m_tdata[25:18]);
                check_field("message_number", want.message_number, m_tdata[33:26]);
                check_field("reference_number", want.reference_number, m_tdata[41:34]);
                check_field("command_code", want.command_code, m_tdata[57:42]);
                check_field("payload_length", want.payload_length, m_tdata[73:58]);
            end
        end
        m_tready <= steady || ($urandom_range(0, 99) >= 12);
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic void queue_byte(logic [7:0] b);
        rx_bytes_queued.push_back(b);
        bytes_queued++;
    endfunction

    // Queue a frame with a correct or corrupted checksum, cut after keep bytes
    task automatic push_frame(input int len, input logic [7:0] dst, input logic [15:0] cmd,
                              input bit corrupt, input int keep);
        logic [7:0] fb[$];
        logic [7:0] sum;
        fb = {SYNC_FIRST, SYNC_SECOND, len[7:0], len[15:8], dst, 8'($urandom),
              8'($urandom), 8'($urandom), cmd[7:0], cmd[15:8]};
        repeat (len - MIN_FRAME_LENGTH) fb.push_back(8'($urandom));
        sum = '0;
        foreach (fb[i]) sum = sum + fb[i];
        fb.push_back(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
        for (int i = 0; i < keep && i < fb.size(); i++)
            queue_byte(fb[i]);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_OWN_ADDRESS)
            own_addr = val[7:0];
        else
            max_len = val;
        cfg_valid <= 1'b0;
    endtask

    // Hold until every byte is taken and every result has come, then let the pipe settle
    task automatic wait_idle();
        do @(posedge aclk);
        while (rx_bytes_queued.size() != 0 || s_tvalid || frame_results_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_dest();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return own_addr;
        else if (r < 60)
            return BROADCAST_ADDR;
        return 8'($urandom);
    endfunction

    function automatic int pick_length();
        int hi;
        if (max_len < MIN_FRAME_LENGTH)
            return $urandom_range(MIN_FRAME_LENGTH, 40);
        hi = (max_len > 48) ? 48 : int'(max_len);
        if ($urandom_range(0, 99) < 3)
            hi = (max_len > 600) ? 600 : int'(max_len);
        return $urandom_range(MIN_FRAME_LENGTH, hi);
    endfunction

    // Mostly well-formed frames, with noise, bad lengths and broken frames
    task automatic random_traffic(input int n);
        int target;
        int r;
        int len;
        logic [15:0] bad;
        target = bytes_queued + n;
        while (bytes_queued < target) begin
            r   = $urandom_range(0, 99);
            len = pick_length();
            if (r < 62) begin
                push_frame(len, pick_dest(), 16'($urandom), 1'b0, len);
            end else if (r < 72) begin
                push_frame(len, pick_dest(), 16'($urandom), 1'b1, len);
            end else if (r < 82) begin
                repeat ($urandom_range(1, 4))
                    queue_byte($urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom));
            end else if (r < 90) begin
                if (max_len < 16'hFFFF && $urandom_range(0, 1))
                    bad = max_len + 16'd1;
                else
                    bad = 16'($urandom_range(0, MIN_FRAME_LENGTH - 1));
                queue_byte(SYNC_FIRST);
                queue_byte(SYNC_SECOND);
                queue_byte(bad[7:0]);
                queue_byte(bad[15:8]);
            end else begin
                push_frame(len, pick_dest(), 16'($urandom), 1'b0, $urandom_range(4, len - 1));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: noise, wrong second sync byte, repeated first sync byte, a one-byte
        // payload frame to broadcast with all-ones command, lengths under and over the limits
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(SYNC_FIRST);
        queue_byte(8'h13);
        queue_byte(SYNC_FIRST);
        push_frame(12, BROADCAST_ADDR, 16'hFFFF, 1'b0, 12);
        queue_byte(SYNC_FIRST);
        queue_byte(SYNC_SECOND);
        queue_byte(8'd10);
        queue_byte(8'd0);
        queue_byte(SYNC_FIRST);
        queue_byte(SYNC_SECOND);
        queue_byte(8'h01);
        queue_byte(8'h04);
        wait_idle();

        // Lowest address, shortest allowed frame
        write_reg(CFG_OWN_ADDRESS, 16'h0000);
        write_reg(CFG_MAX_FRAME_LENGTH, 16'd11);
        random_traffic(100);
        wait_idle();

        // Highest address and length, without any idling
        write_reg(CFG_OWN_ADDRESS, 16'h00FF);
        write_reg(CFG_MAX_FRAME_LENGTH, 16'hFFFF);
        steady = 1'b1;
        random_traffic(150);
        wait_idle();
        steady = 1'b0;

        // Limit under the minimum: nothing gets through
        write_reg(CFG_MAX_FRAME_LENGTH, 16'($urandom_range(0, MIN_FRAME_LENGTH - 1)));
        random_traffic(60);
        wait_idle();

        // Mid-range settings
        write_reg(CFG_OWN_ADDRESS, 16'($urandom_range(0, 255)));
        write_reg(CFG_MAX_FRAME_LENGTH, 16'($urandom_range(MIN_FRAME_LENGTH, 300)));
        random_traffic(290);
        wait_idle();
        repeat (8) @(posedge aclk);

        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
